>>> rtl/rkr_pkg.sv
`default_nettype none

package rkr_pkg;

  // Delay line depth
  localparam int RKR_MAX_WINDOW = 64;

  // Modulus of the residue mode and its distance to 2^64
  localparam logic [63:0] RKR_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [63:0] RKR_FOLD  = 64'd59;

  // Item commands
  localparam logic RKR_CMD_RANK = 1'b0;
  localparam logic RKR_CMD_LOAD = 1'b1;

  // Register indexes of the configuration channel
  localparam logic [7:0] RKR_REG_BASE   = 8'd0;
  localparam logic [7:0] RKR_REG_WEIGHT = 8'd1;
  localparam logic [7:0] RKR_REG_WINDOW = 8'd2;
  localparam logic [7:0] RKR_REG_MODE   = 8'd3;

  // Register reset values
  localparam logic [7:0]  RKR_RST_BASE   = 8'd4;
  localparam logic [63:0] RKR_RST_WEIGHT = 64'd1;
  localparam logic [6:0]  RKR_RST_WINDOW = 7'd1;
  localparam logic        RKR_RST_MODE   = 1'b0;

  // Fill count saturation
  localparam logic [6:0] RKR_FILL_MAX = 7'd127;

  typedef struct packed {
    logic       cmd;
    logic [7:0] symbol;
    logic [7:0] code;
    logic       sequence_start;
  } rkr_in_t;

  typedef struct packed {
    logic [63:0] rank;
  } rkr_out_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [63:0] data;
  } rkr_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_MUL_W,
    ST_RED_W,
    ST_SUB,
    ST_MUL_B,
    ST_RED_B,
    ST_FIN
  } rkr_state_e;

  // Step enables from the sequencer to the datapath
  typedef struct packed {
    logic load_ops;
    logic mul_weight;
    logic mul_base;
    logic reduce;
    logic subtract;
    logic finish;
  } rkr_step_t;

endpackage

`default_nettype wire

>>> rtl/rkr_chan_if.sv
`default_nettype none

interface rkr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rkr_dp.sv
`default_nettype none

module rkr_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rkr_pkg::rkr_step_t step_i,
  input  wire logic             mode_i,
  input  wire logic             start_i,
  input  wire logic [63:0]      top_weight_i,
  input  wire logic [7:0]       base_i,
  input  wire logic [7:0]       code_pop_i,
  input  wire logic [7:0]       code_new_i,
  output logic [63:0]           rank_next_o
);
  import rkr_pkg::*;

  logic [63:0] rank_q, rank_d;
  logic [63:0] w_q, w_d;
  logic [63:0] acc_q, acc_d;
  logic [71:0] prod_q, prod_d;
  logic [63:0] s_q, s_d;
  logic [63:0] rank_src;
  logic [63:0] pop_dist;

  // Reduce a value below 2^64 once against the modulus
  function automatic logic [63:0] red_once(input logic [63:0] x);
    return (x >= RKR_PRIME) ? x - RKR_PRIME : x;
  endfunction

  // Reduce a 72-bit product: fold the top byte as 59 per unit of 2^64
  function automatic logic [63:0] fold_mod(input logic [71:0] p);
    logic [13:0] hi_fold;
    logic [64:0] sum;
    logic [63:0] s;
    hi_fold = 14'(64'(p[71:64]) * RKR_FOLD);
    sum     = {1'b0, p[63:0]} + 65'(hi_fold);
    s       = sum[63:0] + (sum[64] ? RKR_FOLD : 64'd0);
    return red_once(s);
  endfunction

  // Operand setup
  always_comb begin
    rank_src = start_i ? 64'd0 : rank_q;
    w_d      = mode_i ? red_once(top_weight_i) : top_weight_i;
  end

  // Multiply, reduce, subtract
  always_comb begin
    prod_d = step_i.mul_weight ? {8'd0, w_q} * 72'(code_pop_i)
                               : {8'd0, acc_q} * 72'(base_i);
    s_d    = mode_i ? fold_mod(prod_q) : prod_q[63:0];
    acc_d  = mode_i ? red_once(rank_src) : rank_src;
    if (step_i.subtract) begin
      if (!mode_i) begin
        acc_d = acc_q - s_q;
      end else if (acc_q >= s_q) begin
        acc_d = acc_q - s_q;
      end else begin
        acc_d = acc_q + (RKR_PRIME - s_q);
      end
    end
  end

  // Add the new code
  always_comb begin
    pop_dist = RKR_PRIME - 64'(code_new_i);
    if (mode_i && (s_q >= pop_dist)) begin
      rank_d = s_q - pop_dist;
    end else begin
      rank_d = s_q + 64'(code_new_i);
    end
  end

  assign rank_next_o = rank_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else if (step_i.finish) begin
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.load_ops) begin
      w_q <= w_d;
    end
    if (step_i.load_ops || step_i.subtract) begin
      acc_q <= acc_d;
    end
    if (step_i.mul_weight || step_i.mul_base) begin
      prod_q <= prod_d;
    end
    if (step_i.reduce) begin
      s_q <= s_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rolling_kmer_rank.sv
// Rolling window rank over a stream of byte symbols.
// in_i takes one item per beat. cmd load writes a code into the 256-entry
// code table and gives no result. cmd rank looks the symbol up,
// pops the symbol that leaves the window from the delay line and updates the
// running rank as (rank - code_pop * top_weight) * base + code_new, either
// wrapping mod 2^64 or as a residue mod 2^64-59.
// out_o carries one rank beat per rank item once window_length
// symbols of the current sequence have arrived.
// A rank item runs through POP, MUL_W, RED_W, SUB, MUL_B, RED_B and FIN
// before in_i takes the next item: a delay line read, two code table reads,
// then two passes of the 64x8 multiply and fold unit. The result is
// registered as FIN ends; load items are taken in IDLE without leaving it.
// cfg_i writes registers by index any time; write them only while idle.
// Reset clears the code table to zero through per-entry valid bits, empties
// the delay line through the fill count and loads register defaults; there
// is no clearing pass. When out_o stalls, one result waits in the output
// register; a following rank item finishes its work and holds until the
// beat is taken.
`default_nettype none

module rolling_kmer_rank #(
  parameter int MAX_WINDOW = rkr_pkg::RKR_MAX_WINDOW
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rkr_chan_if.sink  in_i,
  rkr_chan_if.sink  cfg_i,
  rkr_chan_if.source out_o
);
  import rkr_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW = AW + 1;

  rkr_in_t  in_data;
  rkr_cfg_t cfg_data;

  // Configuration registers
  logic [7:0]  base_q;
  logic [63:0] weight_q;
  logic [6:0]  window_q;
  logic        mode_q;

  // Sequencer
  rkr_state_e state_q, state_d;
  rkr_step_t  step;
  logic       in_acc, rank_acc, load_acc, cfg_acc;
  logic       slot_free;

  // Window bookkeeping
  logic [AW-1:0] wptr_q;
  logic [6:0]    fill_q;
  logic [6:0]    k_eff;
  logic [6:0]    fill_base, fill_new;
  logic [PW-1:0] wp_ext, k_ext, rd_full;
  logic [AW-1:0] rd_addr;
  logic          start_q, filled_q, emit_q;

  // Memories and their read registers
  logic [7:0]   win_mem [MAX_WINDOW];
  logic [7:0]   win_q;
  logic [7:0]   tab_mem [256];
  logic [255:0] tab_vld_q;
  logic [7:0]   tab_q;
  logic         tab_hit_q;
  logic         tab_rd_en;
  logic [7:0]   tab_addr;
  logic [7:0]   pop_sym;
  logic [7:0]   code_rd;
  logic [7:0]   code_new_q;

  // Output register
  logic        out_vld_q;
  logic [63:0] out_rank_q;
  logic [63:0] rank_next;

  assign in_data  = in_i.data;
  assign cfg_data = cfg_i.data;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign rank_acc    = in_acc && (in_data.cmd == RKR_CMD_RANK);
  assign load_acc    = in_acc && (in_data.cmd == RKR_CMD_LOAD);
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign slot_free   = !out_vld_q || out_o.ready;

  assign out_o.valid     = out_vld_q;
  assign out_o.data.rank = out_rank_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= RKR_RST_BASE;
      weight_q <= RKR_RST_WEIGHT;
      window_q <= RKR_RST_WINDOW;
      mode_q   <= RKR_RST_MODE;
    end else if (cfg_acc) begin
      unique case (cfg_data.index)
        RKR_REG_BASE:   base_q   <= cfg_data.data[7:0];
        RKR_REG_WEIGHT: weight_q <= cfg_data.data;
        RKR_REG_WINDOW: window_q <= cfg_data.data[6:0];
        RKR_REG_MODE:   mode_q   <= cfg_data.data[0];
        default: ;
      endcase
    end
  end

  // Clamp window length to 1..MAX_WINDOW
  always_comb begin
    priority if (window_q == 7'd0) begin
      k_eff = 7'd1;
    end else if (32'(window_q) > MAX_WINDOW) begin
      k_eff = 7'(MAX_WINDOW);
    end else begin
      k_eff = window_q;
    end
  end

  // Locate the symbol k steps back in the circular delay line
  always_comb begin
    wp_ext = PW'(wptr_q);
    k_ext  = PW'(k_eff);
    if (wp_ext >= k_ext) begin
      rd_full = wp_ext - k_ext;
    end else begin
      rd_full = wp_ext + PW'(MAX_WINDOW) - k_ext;
    end
    rd_addr = rd_full[AW-1:0];
  end

  // Advance fill count
  always_comb begin
    fill_base = in_data.sequence_start ? 7'd0 : fill_q;
    fill_new  = (fill_base == RKR_FILL_MAX) ? RKR_FILL_MAX : fill_base + 7'd1;
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (rank_acc) state_d = ST_POP;
      ST_POP:   state_d = ST_MUL_W;
      ST_MUL_W: state_d = ST_RED_W;
      ST_RED_W: state_d = ST_SUB;
      ST_SUB:   state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_RED_B;
      ST_RED_B: state_d = ST_FIN;
      ST_FIN:   if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    step = '0;
    unique case (state_q)
      ST_IDLE:  ;
      ST_POP:   step.load_ops   = 1'b1;
      ST_MUL_W: step.mul_weight = 1'b1;
      ST_RED_W: step.reduce     = 1'b1;
      ST_SUB:   step.subtract   = 1'b1;
      ST_MUL_B: step.mul_base   = 1'b1;
      ST_RED_B: step.reduce     = 1'b1;
      ST_FIN:   step.finish     = slot_free;
      default:  ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wptr_q    <= '0;
      fill_q    <= '0;
      start_q   <= 1'b0;
      filled_q  <= 1'b0;
      emit_q    <= 1'b0;
      tab_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rank_acc) begin
        wptr_q   <= (32'(wptr_q) == MAX_WINDOW - 1) ? '0 : wptr_q + AW'(1);
        fill_q   <= fill_new;
        start_q  <= in_data.sequence_start;
        filled_q <= !in_data.sequence_start && (fill_q >= k_eff);
        emit_q   <= fill_new >= k_eff;
      end
      if (load_acc) begin
        tab_vld_q[in_data.symbol] <= 1'b1;
      end
      if (step.finish && emit_q) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Delay line: write the new symbol, read the one leaving the window
  always_ff @(posedge clk_i) begin
    if (rank_acc) begin
      win_mem[wptr_q] <= in_data.symbol;
      win_q           <= win_mem[rd_addr];
    end
  end

  // Code table: new symbol read on accept, popped symbol read next cycle
  assign pop_sym   = filled_q ? win_q : 8'd0;
  assign tab_rd_en = rank_acc || (state_q == ST_POP);
  assign tab_addr  = (state_q == ST_POP) ? pop_sym : in_data.symbol;
  assign code_rd   = tab_hit_q ? tab_q : 8'd0;

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      tab_mem[in_data.symbol] <= in_data.code;
    end
    if (tab_rd_en) begin
      tab_q     <= tab_mem[tab_addr];
      tab_hit_q <= tab_vld_q[tab_addr];
    end
    if (state_q == ST_POP) begin
      code_new_q <= code_rd;
    end
    if (step.finish && emit_q) begin
      out_rank_q <= rank_next;
    end
  end

  rkr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .mode_i       (mode_q),
    .start_i      (start_q),
    .top_weight_i (weight_q),
    .base_i       (base_q),
    .code_pop_i   (code_rd),
    .code_new_i   (code_new_q),
    .rank_next_o  (rank_next)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rkr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 147;
  localparam int RX_HOLD_CYCLES = 400;

  // Expected-rank tracker: mirrors table, delay line, rank and registers
  class rank_tracker;
    logic [7:0]  code_tab [256];
    logic [7:0]  window_syms [RKR_MAX_WINDOW];
    logic [63:0] rank_acc;
    logic [6:0]  fill;
    logic [7:0]  base;
    logic [63:0] weight;
    logic [6:0]  wlen;
    logic        mode;
    logic [63:0] pending_ranks [$];
    int          errors;

    function new();
      foreach (code_tab[i]) code_tab[i] = 8'd0;
      foreach (window_syms[i]) window_syms[i] = 8'd0;
      rank_acc = 64'd0;
      fill = 7'd0;
      base = RKR_RST_BASE;
      weight = RKR_RST_WEIGHT;
      wlen = RKR_RST_WINDOW;
      mode = RKR_RST_MODE;
      errors = 0;
    endfunction

    // Clamp the window register to the delay line depth
    function int span(logic [6:0] w);
      if (w == 7'd0) return 1;
      if (w > RKR_MAX_WINDOW) return RKR_MAX_WINDOW;
      return int'(w);
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] data);
      case (idx)
        RKR_REG_BASE:   base = data[7:0];
        RKR_REG_WEIGHT: weight = data;
        RKR_REG_WINDOW: wlen = data[6:0];
        RKR_REG_MODE:   mode = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted input beat: load the table or advance the rank
    function void note_item(rkr_in_t item);
      int k;
      logic [7:0] popped;
      logic [7:0] c_pop;
      logic [7:0] c_new;
      logic [127:0] c;
      logic [127:0] w;
      logic [127:0] s;
      logic [127:0] t;
      logic [127:0] r;
      if (item.cmd == RKR_CMD_LOAD) begin
        code_tab[item.symbol] = item.code;
        return;
      end
      if (item.sequence_start) begin
        rank_acc = 64'd0;
        fill = 7'd0;
        foreach (window_syms[i]) window_syms[i] = 8'd0;
      end
      k = span(wlen);
      popped = window_syms[k - 1];
      for (int i = RKR_MAX_WINDOW - 1; i > 0; i--) window_syms[i] = window_syms[i - 1];
      window_syms[0] = item.symbol;
      c_pop = code_tab[popped];
      c_new = code_tab[item.symbol];
      if (mode == 1'b0) begin
        rank_acc = (rank_acc - c_pop * weight) * base + c_new;
      end else begin
        // true residue arithmetic, operands reduced first
        c = rank_acc % RKR_PRIME;
        w = weight % RKR_PRIME;
        s = (w * c_pop) % RKR_PRIME;
        t = (c + RKR_PRIME - s) % RKR_PRIME;
        r = (t * base + c_new) % RKR_PRIME;
        rank_acc = r[63:0];
      end
      if (fill < RKR_FILL_MAX) fill++;
      if (int'(fill) >= k) pending_ranks = {pending_ranks, rank_acc};
    endfunction

    function void check_rank(rkr_out_t beat);
      logic [63:0] want;
      if (pending_ranks.size() == 0) begin
        $error("rank beat with nothing pending: rank actual %h", beat.rank);
        errors++;
        return;
      end
      want = pending_ranks.pop_front();
      if (beat.rank !== want) begin
        $error("rank mismatch: expected %h actual %h", want, beat.rank);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_rx;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase_no = -1;
  int   cycle_count = 0;
  rank_tracker tracker;

  rkr_chan_if #(.T(rkr_in_t))  in_if ();
  rkr_chan_if #(.T(rkr_cfg_t)) cfg_if ();
  rkr_chan_if #(.T(rkr_out_t)) out_if ();

  rolling_kmer_rank u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Observe accepted beats on all channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) tracker.check_rank(out_if.data);
      if (in_if.valid && in_if.ready) tracker.note_item(in_if.data);
      if (cfg_if.valid && cfg_if.ready) tracker.write_reg(cfg_if.data.index, cfg_if.data.data);
    end
  end

  // Drive result ready with random stalls
  always @(posedge clk_i) begin
    out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin
    hold_rx = 1'b0;
    wait (phase_no == 1);
    hold_rx <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Offer one input beat, idling at random first; valid stays high afterwards
  task automatic send_item(input rkr_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Wait until every expected rank is out and the block has settled
  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_ranks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [7:0] base, input logic [63:0] weight,
                                input logic [6:0] wlen, input logic mode);
    rkr_cfg_t wr [4];
    wr[0] = '{RKR_REG_BASE, 64'(base)};
    wr[1] = '{RKR_REG_WEIGHT, weight};
    wr[2] = '{RKR_REG_WINDOW, 64'(wlen)};
    wr[3] = '{RKR_REG_MODE, 64'(mode)};
    foreach (wr[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= wr[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed sequences with table loads and stray restarts mixed in
  task automatic send_sequences(input int n_items, input int k_eff, input int carry);
    rkr_in_t item;
    int seq_left;
    int roll;
    seq_left = carry;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      item.code = 8'($urandom_range(255));
      item.symbol = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      if (roll < 9) begin
        item.cmd = RKR_CMD_LOAD;
        item.sequence_start = 1'($urandom_range(1));
        if (roll < 2) item.code = (roll == 0) ? 8'd0 : 8'd255;
      end else begin
        item.cmd = RKR_CMD_RANK;
        if (seq_left == 0) begin
          item.sequence_start = 1'b1;
          seq_left = $urandom_range(1, 2 * k_eff + 8);
        end else begin
          item.sequence_start = ($urandom_range(99) < 3);
        end
        seq_left--;
      end
      send_item(item);
    end
  endtask

  initial begin
    logic [7:0]  ph_base;
    logic [63:0] ph_weight;
    logic [6:0]  ph_wlen;
    logic        ph_mode;
    int          carry;
    tracker = new();
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, empty table, field extremes
    send_idle_pct = 19;
    recv_idle_pct = 78;
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd7, 8'd0, 1'b1});
    send_item(rkr_in_t'{RKR_CMD_LOAD, 8'd0, 8'd255, 1'b1});
    send_item(rkr_in_t'{RKR_CMD_LOAD, 8'd255, 8'd255, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_LOAD, 8'd1, 8'd1, 1'b1});
    send_item(rkr_in_t'{RKR_CMD_LOAD, 8'd128, 8'd128, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd255, 8'd0, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd0, 8'd255, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd1, 8'd0, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd128, 8'd0, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd255, 8'd0, 1'b1});

    // Drive the wrapped rank to 2^64-254, below the prime, then switch to residue mode
    drain_block();
    write_settings(8'd1, 64'd1, 7'd1, 1'b0);
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd1, 8'd0, 1'b1});
    drain_block();
    write_settings(8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 1'b1);
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd1, 8'd0, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd0, 8'd0, 1'b0});
    send_item(rkr_in_t'{RKR_CMD_RANK, 8'd255, 8'd0, 1'b0});

    // Random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      drain_block();
      carry = 0;
      case (p)
        0: begin
          ph_base = 8'd255; ph_weight = 64'hFFFF_FFFF_FFFF_FFFF; ph_wlen = 7'd64; ph_mode = 1'b0;
        end
        1: begin
          ph_base = 8'd0; ph_weight = 64'd0; ph_wlen = 7'd0; ph_mode = 1'b1; carry = 6;
        end
        2: begin
          ph_base = 8'd4; ph_weight = RKR_PRIME + 64'd5; ph_wlen = 7'd3; ph_mode = 1'b1;
        end
        3: begin
          ph_base = 8'd255; ph_weight = {$urandom, $urandom}; ph_wlen = 7'd127; ph_mode = 1'b1;
          carry = 4;
        end
        4: begin
          ph_base = 8'd7; ph_weight = {$urandom, $urandom}; ph_wlen = 7'd5; ph_mode = 1'b0;
        end
        5: begin
          ph_base = 8'($urandom_range(255)); ph_weight = {$urandom, $urandom};
          ph_wlen = 7'($urandom_range(1, 8)); ph_mode = 1'b1;
        end
        6: begin
          ph_base = 8'd2; ph_weight = 64'd2; ph_wlen = 7'd2; ph_mode = 1'b0;
        end
        default: begin
          ph_base = 8'($urandom_range(255)); ph_weight = {$urandom, $urandom};
          ph_wlen = 7'($urandom_range(16)); ph_mode = 1'($urandom_range(1));
        end
      endcase
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 78;
      end else if (p < 6) begin
        send_idle_pct = 78;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_settings(ph_base, ph_weight, ph_wlen, ph_mode);
      phase_no = p;
      send_sequences(PHASE_ITEMS, tracker.span(ph_wlen), carry);
    end

    drain_block();
    if (tracker.pending_ranks.size() != 0) begin
      $error("%0d expected ranks never arrived", tracker.pending_ranks.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rkr_pkg.sv
rtl/rkr_chan_if.sv
rtl/rkr_dp.sv
rtl/rolling_kmer_rank.sv
bench/tb.sv
